/* rtl/kse_pkg.sv */
// Package: shared constants, types and lookup functions of the keyed substitution encoder.
`timescale 1ns / 1ps
`default_nettype none
package kse_pkg;

  localparam int KEY_LENGTH = 13;
  localparam int KPOS_W     = 4;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // One encoded byte with the checksum after it, as passed from front to back.
  typedef struct packed {
    logic [7:0]  coded;
    logic [15:0] sum;
    logic        last;
  } kse_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kse_q_stat_t;

  function automatic logic [4:0] key_weight(input logic [KPOS_W-1:0] pos);
    logic [4:0] w;
    unique case (pos)
      4'd0:    w = 5'd9;
      4'd1:    w = 5'd2;
      4'd2:    w = 5'd5;
      4'd3:    w = 5'd8;
      4'd4:    w = 5'd1;
      4'd5:    w = 5'd7;
      4'd6:    w = 5'd3;
      4'd7:    w = 5'd4;
      4'd8:    w = 5'd13;
      4'd9:    w = 5'd18;
      4'd10:   w = 5'd11;
      4'd11:   w = 5'd5;
      4'd12:   w = 5'd17;
      default: w = 5'd9;  // out-of-range position acts as position zero
    endcase
    return w;
  endfunction

  function automatic logic [6:0] subst_code(input logic [7:0] c);
    logic [6:0] r;
    unique case (c)
      8'h30:   r = 7'd63;  // '0'
      8'h31:   r = 7'd12;
      8'h32:   r = 7'd37;
      8'h33:   r = 7'd13;
      8'h34:   r = 7'd64;
      8'h35:   r = 7'd65;
      8'h36:   r = 7'd22;
      8'h37:   r = 7'd23;
      8'h38:   r = 7'd30;
      8'h39:   r = 7'd31;
      8'h2e:   r = 7'd33;  // '.'
      8'h2a:   r = 7'd34;  // '*'
      8'h2c:   r = 7'd35;  // ','
      8'h5c:   r = 7'd36;  // backslash
      8'h0d:   r = 7'd50;  // CR
      8'h0a:   r = 7'd51;  // LF
      8'h3a:   r = 7'd66;  // ':'
      default: begin
        if (c >= 8'h61 && c <= 8'h6b)      r = 7'(c - 8'h61 + 8'd1);
        else if (c >= 8'h6c && c <= 8'h73) r = 7'(c - 8'h6c + 8'd14);
        else if (c >= 8'h74 && c <= 8'h79) r = 7'(c - 8'h74 + 8'd24);
        else if (c == 8'h7a)               r = 7'd32;
        else if (c >= 8'h41 && c <= 8'h4c) r = 7'(c - 8'h41 + 8'd38);
        else if (c >= 8'h4d && c <= 8'h57) r = 7'(c - 8'h4d + 8'd52);
        else                               r = 7'd0;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/kse_ifs.sv */
// Interfaces: input text channel and coded result channel.
`timescale 1ns / 1ps
`default_nettype none
interface kse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface kse_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  coded_byte;
  logic        is_trailer;
  logic        final_result;
  logic [15:0] checksum_value;
  modport source (output valid, output coded_byte, output is_trailer,
                  output final_result, output checksum_value, input ready);
  modport sink   (input valid, input coded_byte, input is_trailer,
                  input final_result, input checksum_value, output ready);
endinterface
`default_nettype wire

/* rtl/kse_front.sv */
// Front end: accepts text bytes, substitutes, adds key weight, keeps the checksum.
`timescale 1ns / 1ps
`default_nettype none
module kse_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  kse_in_if.sink                in_ch,
  input  wire kse_pkg::kse_q_stat_t q_stat,
  output logic                  q_push,
  output kse_pkg::kse_rec_t     q_rec
);
  import kse_pkg::*;

  logic [KPOS_W-1:0] key_pos_r, key_pos_nxt, pos_eff;
  logic [15:0]       sum_r, sum_nxt;
  logic [7:0]        coded;

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && in_ch.ready;

  always_comb begin
    pos_eff = (key_pos_r >= KPOS_W'(KEY_LENGTH)) ? '0 : key_pos_r;
    coded   = 8'(subst_code(in_ch.text_byte)) + 8'(key_weight(pos_eff));
    sum_nxt = sum_r + 16'(coded);
    key_pos_nxt = (pos_eff == KPOS_W'(KEY_LENGTH - 1)) ? '0 : pos_eff + 1'b1;
    q_rec.coded = coded;
    q_rec.sum   = sum_nxt;
    q_rec.last  = in_ch.end_of_text;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r <= '0;
      sum_r     <= '0;
    end else if (q_push) begin
      // stream end: start the next one fresh
      key_pos_r <= in_ch.end_of_text ? '0 : key_pos_nxt;
      sum_r     <= in_ch.end_of_text ? '0 : sum_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/kse_queue.sv */
// Small FIFO of encoded records between front and back.
`timescale 1ns / 1ps
`default_nettype none
module kse_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire kse_pkg::kse_rec_t wr_rec,
  input  wire logic              pop,
  output kse_pkg::kse_rec_t      rd_rec,
  output kse_pkg::kse_q_stat_t   stat
);
  import kse_pkg::*;

  kse_rec_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_rec     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/kse_back.sv */
// Back end: emits coded bytes and the two checksum trailer bytes per stream.
`timescale 1ns / 1ps
`default_nettype none
module kse_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire kse_pkg::kse_rec_t    q_rec,
  input  wire kse_pkg::kse_q_stat_t q_stat,
  output logic                      q_pop,
  kse_out_if.source                 out_ch
);
  import kse_pkg::*;

  typedef enum logic [1:0] {PH_DATA, PH_TR_LO, PH_TR_HI} phase_t;

  phase_t      phase_r;
  logic        out_valid_r;
  logic [7:0]  coded_r;
  logic        trailer_r;
  logic        final_r;
  logic [15:0] sum_r;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = slot_free && (phase_r == PH_DATA) && !q_stat.empty;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.coded_byte     = coded_r;
  assign out_ch.is_trailer     = trailer_r;
  assign out_ch.final_result   = final_r;
  assign out_ch.checksum_value = sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      unique case (phase_r)
        PH_TR_LO: begin
          out_valid_r <= 1'b1;
          coded_r     <= sum_r[7:0];
          trailer_r   <= 1'b1;
          final_r     <= 1'b0;
          phase_r     <= PH_TR_HI;
        end
        PH_TR_HI: begin
          out_valid_r <= 1'b1;
          coded_r     <= sum_r[15:8];
          trailer_r   <= 1'b1;
          final_r     <= 1'b1;
          phase_r     <= PH_DATA;
        end
        default: begin
          out_valid_r <= !q_stat.empty;
          if (!q_stat.empty) begin
            coded_r   <= q_rec.coded;
            sum_r     <= q_rec.sum;
            trailer_r <= 1'b0;
            final_r   <= 1'b0;
            phase_r   <= q_rec.last ? PH_TR_LO : PH_DATA;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/keyed_substitution_encoder.sv */
// Top level of the keyed substitution encoder.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one text byte per cycle while the queue has room and returns one
// coded byte per request; the request marked end_of_text adds two more
// results, the 16-bit checksum low byte then high byte, the latter flagged
// final_result, after which key position and checksum restart from zero.
// Table lookup, key add and checksum accumulate are combinational in the
// front end; a 4-entry queue decouples it from the output register. Sustained
// output is one result per cycle while the sink keeps ready high, so a stream
// of N bytes gives N + 2 results. A coded byte is written into the queue and
// then loaded into the output register before it is presented.
module keyed_substitution_encoder (
  input  wire logic clk,
  input  wire logic rst_n,
  kse_in_if.sink    in_ch,
  kse_out_if.source out_ch
);
  import kse_pkg::*;

  kse_q_stat_t q_stat;
  kse_rec_t    push_rec, head_rec;
  logic        q_push, q_pop;

  kse_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_rec  (push_rec)
  );

  kse_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (push_rec),
    .pop    (q_pop),
    .rd_rec (head_rec),
    .stat   (q_stat)
  );

  kse_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rec  (head_rec),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_final_is_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.final_result |-> out_ch.is_trailer)
    else $error("final result not a trailer byte");

  a_hi_follows_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.is_trailer && !out_ch.final_result
    |=> out_ch.valid && out_ch.is_trailer && out_ch.final_result)
    else $error("checksum high byte did not follow low byte");

  a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && in_ch.end_of_text |=> !q_stat.empty)
    else $error("last request lost from queue");
endmodule
`default_nettype wire

/* bench/kse_result_checker.sv */
// Checker: predicts the coded byte stream of the encoder and compares every result.
`timescale 1ns / 1ps
module kse_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_coded_byte,
  input  logic        out_is_trailer,
  input  logic        out_final_result,
  input  logic [15:0] out_checksum_value,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          streams_done
);

  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic [7:0]  coded_byte;
    logic        is_trailer;
    logic        final_result;
    logic [15:0] checksum_value;
  } coded_result_t;

  coded_result_t coded_due[$];
  logic [3:0]    key_pos;
  logic [15:0]   run_sum;
  int            fails;
  int            checked;
  int            streams;

  function automatic logic [7:0] symbol_code(input logic [7:0] c);
    case (c)
      "0":    return 8'd63;
      "1":    return 8'd12;
      "2":    return 8'd37;
      "3":    return 8'd13;
      "4":    return 8'd64;
      "5":    return 8'd65;
      "6":    return 8'd22;
      "7":    return 8'd23;
      "8":    return 8'd30;
      "9":    return 8'd31;
      ".":    return 8'd33;
      "*":    return 8'd34;
      ",":    return 8'd35;
      "\\":   return 8'd36;
      8'h0d:  return 8'd50;
      8'h0a:  return 8'd51;
      ":":    return 8'd66;
      default: begin
        if (c >= "a" && c <= "k") return c - "a" + 8'd1;
        if (c >= "l" && c <= "s") return c - "l" + 8'd14;
        if (c >= "t" && c <= "y") return c - "t" + 8'd24;
        if (c == "z")             return 8'd32;
        if (c >= "A" && c <= "L") return c - "A" + 8'd38;
        if (c >= "M" && c <= "W") return c - "M" + 8'd52;
        return 8'd0;  // X, Y, Z, high bytes and everything else
      end
    endcase
  endfunction

  function automatic logic [7:0] weight_at(input logic [3:0] pos);
    case (pos)
      4'd1:    return 8'd2;
      4'd2:    return 8'd5;
      4'd3:    return 8'd8;
      4'd4:    return 8'd1;
      4'd5:    return 8'd7;
      4'd6:    return 8'd3;
      4'd7:    return 8'd4;
      4'd8:    return 8'd13;
      4'd9:    return 8'd18;
      4'd10:   return 8'd11;
      4'd11:   return 8'd5;
      4'd12:   return 8'd17;
      default: return 8'd9;
    endcase
  endfunction

  // Pushes the coded byte and, at end of text, the two checksum bytes.
  task automatic predict_codes(input logic [7:0] text, input logic last);
    logic [3:0] pos;
    logic [7:0] coded;
    pos = (key_pos >= kse_pkg::KEY_LENGTH) ? 4'd0 : key_pos;
    coded = symbol_code(text) + weight_at(pos);
    run_sum = run_sum + {8'd0, coded};
    pos = pos + 4'd1;
    key_pos = (pos >= kse_pkg::KEY_LENGTH) ? 4'd0 : pos;
    coded_due.push_back('{coded, 1'b0, 1'b0, run_sum});
    if (last) begin
      coded_due.push_back('{run_sum[7:0], 1'b1, 1'b0, run_sum});
      coded_due.push_back('{run_sum[15:8], 1'b1, 1'b1, run_sum});
      key_pos = 4'd0;
      run_sum = 16'd0;
    end
  endtask

  always @(posedge clk) begin
    coded_result_t want;
    coded_result_t got;
    if (!rst_n) begin
      coded_due.delete();
      key_pos = 4'd0;
      run_sum = 16'd0;
      fails   = 0;
      checked = 0;
      streams = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_coded_byte, out_is_trailer, out_final_result, out_checksum_value};
        if (coded_due.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t ns: unexpected result coded=%0d trailer=%0b final=%0b sum=%0d",
                     $time, got.coded_byte, got.is_trailer, got.final_result,
                     got.checksum_value);
        end else begin
          want = coded_due.pop_front();
          checked++;
          if (want.final_result) streams++;
          if (got !== want) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display({"%0t ns: mismatch expected coded=%0d trailer=%0b final=%0b sum=%0d,",
                        " actual coded=%0d trailer=%0b final=%0b sum=%0d"},
                       $time, want.coded_byte, want.is_trailer, want.final_result,
                       want.checksum_value, got.coded_byte, got.is_trailer,
                       got.final_result, got.checksum_value);
          end
        end
      end
      if (in_valid && in_ready) predict_codes(in_text_byte, in_end_of_text);
    end
    fail_count      <= fails;
    pending         <= coded_due.size();
    results_checked <= checked;
    streams_done    <= streams;
  end

endmodule

/* bench/tb_top.sv */
// Testbench top: drives text streams into the encoder and reports the verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 200;
  localparam int LONG_STREAM  = 100;  // high codes push the checksum high byte up
  localparam int TAIL_CYCLES  = 8;

  logic clk;
  logic rst_n;

  kse_in_if  in_ch();
  kse_out_if out_ch();

  int fail_count;
  int pending;
  int results_checked;
  int streams_done;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;  // while set, neither side inserts gaps

  string      text_chars = " abcdefghijklmnopqrstuvwxyz0123456789.*,\\ABCDEFGHIJKLMNOPQRSTUVWXYZ:";
  logic [7:0] corner_text [22];

  keyed_substitution_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kse_result_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_text_byte       (in_ch.text_byte),
    .in_end_of_text     (in_ch.end_of_text),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_coded_byte     (out_ch.coded_byte),
    .out_is_trailer     (out_ch.is_trailer),
    .out_final_result   (out_ch.final_result),
    .out_checksum_value (out_ch.checksum_value),
    .fail_count         (fail_count),
    .pending            (pending),
    .results_checked    (results_checked),
    .streams_done       (streams_done)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return text_chars[$urandom_range(0, text_chars.len() - 1)];
    if (r < 76) return ($urandom_range(0, 1) == 0) ? 8'h0d : 8'h0a;
    if (r < 88) return 8'($urandom_range(0, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] text, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= text;
    in_ch.end_of_text <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_stream(input int len);
    for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
  endtask

  // Result side: random backpressure.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0 && !steady) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no request or result for %0d cycles, %0d results pending",
               IDLE_LIMIT, pending);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int streams_sent;
    int len;
    int r;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = 8'h00;
    in_ch.end_of_text = 1'b0;
    rst_n             = 1'b0;
    corner_text = '{8'h00, 8'hff, 8'h80, 8'h7f, "X", "Y", "Z", " ", "a", "k", "l",
                    "s", "t", "y", "A", "L", "M", "W", 8'h0d, 8'h0a, "0", ":"};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single-byte stream, then one stream through the table corners (wraps the key).
    send_byte("z", 1'b1);
    foreach (corner_text[i]) send_byte(corner_text[i], i == 21);

    streams_sent = 0;
    while (bytes_sent < RANDOM_ITEMS + 23) begin
      if (streams_sent == 2) steady = 1'b1;
      if (streams_sent == 5) steady = 1'b0;
      if (streams_sent == 6) begin
        // hold off until the encoder has drained completely
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 15)      len = 1;
      else if (r < 85) len = $urandom_range(2, 16);
      else             len = $urandom_range(17, 40);
      send_stream(len);
      streams_sent++;
    end

    // Long stream of high codes so the checksum high byte is well above zero.
    for (int i = 0; i < LONG_STREAM; i++)
      send_byte(($urandom_range(0, 1) == 0) ? ":" : "5", i == LONG_STREAM - 1);

    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d streams, %0d text bytes, %0d results checked, %0d failures",
             streams_done, bytes_sent, results_checked, fail_count);
    $display("Table corners, random streams of 1 to 40 bytes with backpressure, long high-code stream");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
